[hw/rtl/sfd_pkg.sv]
package sfd_pkg;

	// defaults for the top level parameters
	localparam int DEF_HISTORY_DEPTH = 8;
	localparam int DEF_NUM_CLASSES   = 4;

	// field widths
	localparam int SLOT_COUNT = 4;
	localparam int SCORE_W    = 16;
	localparam int CLASS_W    = 3;
	localparam int CFG_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int SEQ_CNT_W  = 6;

	// register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_PRE_HOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSITION = 2'd1;
	localparam logic [CFG_W-1:0]     PRE_HOLD_RST   = 4'd2;
	localparam logic [CFG_W-1:0]     TRANSITION_RST = 4'd6;

	// class codes
	localparam logic [CLASS_W-1:0] CLS_NONE     = 3'd0;
	localparam logic [CLASS_W-1:0] CLS_LYING    = 3'd1;
	localparam logic [CLASS_W-1:0] CLS_STANDING = 3'd2;
	localparam logic [CLASS_W-1:0] CLS_SITTING  = 3'd3;
	localparam logic [CLASS_W-1:0] CLS_FALLING  = 3'd4;

	localparam logic [SEQ_CNT_W-1:0] COUNT_MAX = 6'd63;

	typedef struct packed {
		logic [CFG_W-1:0] pre_hold;
		logic [CFG_W-1:0] transition;
	} fall_cfg_t;

	typedef struct packed {
		logic [CLASS_W-1:0] published;
		logic               active;
	} fall_res_t;

endpackage

[hw/rtl/sfd_if.sv]
interface sfd_in_if;
	logic                        valid;
	logic                        ready;
	logic [sfd_pkg::SCORE_W-1:0] score_0;
	logic [sfd_pkg::SCORE_W-1:0] score_1;
	logic [sfd_pkg::SCORE_W-1:0] score_2;
	logic [sfd_pkg::SCORE_W-1:0] score_3;

	modport source (output valid, output score_0, output score_1, output score_2,
		output score_3, input ready);
	modport sink (input valid, input score_0, input score_1, input score_2,
		input score_3, output ready);
endinterface

interface sfd_out_if;
	logic                        valid;
	logic                        ready;
	logic [sfd_pkg::SCORE_W-1:0] avg_0;
	logic [sfd_pkg::SCORE_W-1:0] avg_1;
	logic [sfd_pkg::SCORE_W-1:0] avg_2;
	logic [sfd_pkg::SCORE_W-1:0] avg_3;
	logic [sfd_pkg::CLASS_W-1:0] raw_class;
	logic [sfd_pkg::CLASS_W-1:0] published_class;
	logic                        fall_active;

	modport source (output valid, output avg_0, output avg_1, output avg_2, output avg_3,
		output raw_class, output published_class, output fall_active, input ready);
	modport sink (input valid, input avg_0, input avg_1, input avg_2, input avg_3,
		input raw_class, input published_class, input fall_active, output ready);
endinterface

[hw/rtl/sfd_ram.sv]
module sfd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/sfd_div.sv]
module sfd_div #(
	parameter int DIVIDEND_W = 19,
	parameter int DIVISOR_W  = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CW = $clog2(DIVIDEND_W);

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         step_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  div_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    trial;
	logic                  fits;
	logic [DIVISOR_W:0]    trial_sub;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign trial     = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits      = trial >= {1'b0, div_q};
	assign trial_sub = trial - {1'b0, div_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + CW'(1);
				if (step_q == CW'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, quotient bits replace dividend bits from the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hw/rtl/sfd_fall.sv]
module sfd_fall (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        update,
	input  logic [sfd_pkg::CLASS_W-1:0] raw,
	input  sfd_pkg::fall_cfg_t          cfg,
	output sfd_pkg::fall_res_t          res
);

	logic [sfd_pkg::CLASS_W-1:0]   prev_q;
	logic                          active_q;
	logic [sfd_pkg::SEQ_CNT_W-1:0] count_q;
	logic [sfd_pkg::CLASS_W-1:0]   upright_q;

	logic                          lying;
	logic                          seq_start;
	logic                          in_seq;
	logic [sfd_pkg::SEQ_CNT_W-1:0] cnt_base;
	logic [sfd_pkg::SEQ_CNT_W-1:0] cnt_inc;
	logic [sfd_pkg::CLASS_W-1:0]   up_base;
	logic [sfd_pkg::CFG_W:0]       fall_end;
	logic                          nxt_active;
	logic [sfd_pkg::SEQ_CNT_W-1:0] nxt_count;
	logic [sfd_pkg::CLASS_W-1:0]   nxt_upright;
	logic [sfd_pkg::CLASS_W-1:0]   pub;

	// upright to lying starts a sequence, any other class ends it
	always_comb begin
		lying     = raw == sfd_pkg::CLS_LYING;
		seq_start = !active_q && lying
			&& (prev_q == sfd_pkg::CLS_STANDING || prev_q == sfd_pkg::CLS_SITTING);
		in_seq    = active_q || seq_start;
		cnt_base  = seq_start ? '0 : count_q;
		up_base   = seq_start ? prev_q : upright_q;
		cnt_inc   = (cnt_base < sfd_pkg::COUNT_MAX) ? cnt_base + 6'd1 : cnt_base;
		fall_end  = {1'b0, cfg.pre_hold} + {1'b0, cfg.transition};

		pub         = raw;
		nxt_active  = active_q;
		nxt_count   = count_q;
		nxt_upright = upright_q;
		if (in_seq) begin
			if (!lying) begin
				nxt_active  = 1'b0;
				nxt_count   = '0;
				nxt_upright = sfd_pkg::CLS_NONE;
			end else begin
				nxt_active  = 1'b1;
				nxt_count   = cnt_inc;
				nxt_upright = up_base;
				if (cnt_inc <= {2'b00, cfg.pre_hold}) begin
					pub = up_base;
				end else if (cnt_inc <= {1'b0, fall_end}) begin
					pub = sfd_pkg::CLS_FALLING;
				end else begin
					pub = sfd_pkg::CLS_LYING;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= sfd_pkg::CLS_NONE;
			active_q  <= 1'b0;
			count_q   <= '0;
			upright_q <= sfd_pkg::CLS_NONE;
		end else if (update) begin
			prev_q    <= raw;
			active_q  <= nxt_active;
			count_q   <= nxt_count;
			upright_q <= nxt_upright;
		end
	end

	assign res.published = pub;
	assign res.active    = nxt_active;

endmodule

[hw/rtl/score_smoothing_fall_detector.sv]
// Score smoothing and fall detection.
// score_in takes one frame of class scores (unsigned Q0.16) per request;
// result_out returns one request per frame with the windowed averages, the
// argmax class, the class after fall filtering and the fall-in-progress flag.
// cfg_we/cfg_index/cfg_data write pre_hold_frames (index 0) and
// transition_frames (index 1); only write them while no frame is in flight.
// Averages come from the bit-serial divider, shared by all classes, which
// divides each SW = 16 + log2(HISTORY_DEPTH) bit running sum by the frame
// count and forms one average bit per cycle, one class after the other. The
// next frame is taken once the result has been loaded into the output register.
// Reset clears the running sums, the frame count, the ring pointer and the
// fall state, and loads the registers with 2 and 6. The history ring is not
// cleared: an entry is read back only once it has been written.
// The result sits in an output register. While the receiver stalls, the
// next frame is still accepted and processed, and waits for the output
// register to empty before its result is published.
module score_smoothing_fall_detector #(
	parameter int HISTORY_DEPTH = sfd_pkg::DEF_HISTORY_DEPTH,
	parameter int NUM_CLASSES   = sfd_pkg::DEF_NUM_CLASSES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfd_pkg::CFG_W-1:0]     cfg_data,
	sfd_in_if.sink                        score_in,
	sfd_out_if.source                     result_out
);

	localparam int SCW = sfd_pkg::SCORE_W;
	localparam int SW  = SCW + $clog2(HISTORY_DEPTH);
	localparam int FW  = $clog2(HISTORY_DEPTH + 1);
	localparam int IW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int KW  = $clog2(NUM_CLASSES);
	localparam int RW  = NUM_CLASSES * SCW;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_READ    = 6'b000010,
		ST_UPDATE  = 6'b000100,
		ST_DIVGO   = 6'b001000,
		ST_DIVWAIT = 6'b010000,
		ST_PUB     = 6'b100000
	} state_t;

	state_t                      state_q;
	sfd_pkg::fall_cfg_t          cfg_q;
	logic [SCW-1:0]              in_score [sfd_pkg::SLOT_COUNT];
	logic [SCW-1:0]              score_q [NUM_CLASSES];
	logic [SW-1:0]               sum_q [NUM_CLASSES];
	logic [SCW-1:0]              avg_q [NUM_CLASSES];
	logic [FW-1:0]               frames_q;
	logic [IW-1:0]               wi_q;
	logic [KW-1:0]               k_q;
	logic [KW-1:0]               k_inc;
	logic [KW-1:0]               div_k;
	logic [KW-1:0]               best_q;
	logic [SCW-1:0]              best_val_q;
	logic                        full;
	logic                        k_last;
	logic [RW-1:0]               ram_wdata;
	logic [RW-1:0]               ram_rdata;
	logic                        div_start;
	logic                        div_done;
	logic [SW-1:0]               div_quo;
	logic [SCW-1:0]              quo16;
	logic [sfd_pkg::CLASS_W-1:0] raw;
	sfd_pkg::fall_res_t          fall_res;
	logic                        out_load;
	logic                        out_valid_q;
	logic [SCW-1:0]              out_avg_q [NUM_CLASSES];
	logic [SCW-1:0]              avg_port [sfd_pkg::SLOT_COUNT];
	logic [sfd_pkg::CLASS_W-1:0] out_raw_q;
	logic [sfd_pkg::CLASS_W-1:0] out_pub_q;
	logic                        out_active_q;

	assign in_score[0] = score_in.score_0;
	assign in_score[1] = score_in.score_1;
	assign in_score[2] = score_in.score_2;
	assign in_score[3] = score_in.score_3;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pre_hold   <= sfd_pkg::PRE_HOLD_RST;
			cfg_q.transition <= sfd_pkg::TRANSITION_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfd_pkg::REG_PRE_HOLD:   cfg_q.pre_hold   <= cfg_data;
				sfd_pkg::REG_TRANSITION: cfg_q.transition <= cfg_data;
				default: ;
			endcase
		end
	end

	assign full     = frames_q == FW'(HISTORY_DEPTH);
	assign k_inc    = k_q + KW'(1);
	assign k_last   = k_q == KW'(NUM_CLASSES - 1);
	assign div_k    = (state_q == ST_DIVGO) ? k_q : k_inc;
	assign div_start = (state_q == ST_DIVGO) || (state_q == ST_DIVWAIT && div_done && !k_last);
	assign quo16    = div_quo[SCW-1:0];
	assign raw      = sfd_pkg::CLASS_W'(best_q) + sfd_pkg::CLASS_W'(1);
	assign out_load = (state_q == ST_PUB) && (!out_valid_q || result_out.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			frames_q <= '0;
			wi_q     <= '0;
			k_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (score_in.valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_UPDATE;
				ST_UPDATE: begin
					if (!full) begin
						frames_q <= frames_q + FW'(1);
					end
					wi_q    <= (wi_q == IW'(HISTORY_DEPTH - 1)) ? '0 : wi_q + IW'(1);
					k_q     <= '0;
					state_q <= ST_DIVGO;
				end
				ST_DIVGO: state_q <= ST_DIVWAIT;
				ST_DIVWAIT: begin
					if (div_done) begin
						if (k_last) begin
							state_q <= ST_PUB;
						end else begin
							k_q <= k_inc;
						end
					end
				end
				ST_PUB: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// score capture, running sums, averages and argmax
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				sum_q[i] <= '0;
			end
		end else if (state_q == ST_UPDATE) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				sum_q[i] <= sum_q[i]
					- (full ? SW'(ram_rdata[i*SCW +: SCW]) : SW'(0))
					+ SW'(score_q[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && score_in.valid) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				score_q[i] <= in_score[i];
			end
		end
		if (state_q == ST_DIVWAIT && div_done) begin
			avg_q[k_q] <= quo16;
			// strict compare keeps the lowest index on ties
			if (k_q == '0 || quo16 > best_val_q) begin
				best_q     <= k_q;
				best_val_q <= quo16;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_CLASSES; i++) begin
			ram_wdata[i*SCW +: SCW] = score_q[i];
		end
	end

	sfd_ram #(
		.WIDTH (RW),
		.DEPTH (HISTORY_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (state_q == ST_UPDATE),
		.waddr (wi_q),
		.wdata (ram_wdata),
		.re    (state_q == ST_READ),
		.raddr (wi_q),
		.rdata (ram_rdata)
	);

	sfd_div #(
		.DIVIDEND_W (SW),
		.DIVISOR_W  (FW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q[div_k]),
		.divisor  (frames_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	sfd_fall u_fall (
		.clk    (clk),
		.arst_n (arst_n),
		.update (out_load),
		.raw    (raw),
		.cfg    (cfg_q),
		.res    (fall_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				out_avg_q[i] <= avg_q[i];
			end
			out_raw_q    <= raw;
			out_pub_q    <= fall_res.published;
			out_active_q <= fall_res.active;
		end
	end

	// missing classes report zero
	for (genvar g = 0; g < sfd_pkg::SLOT_COUNT; g++) begin : g_avg
		if (g < NUM_CLASSES) begin : g_used
			assign avg_port[g] = out_avg_q[g];
		end else begin : g_unused
			assign avg_port[g] = '0;
		end
	end

	assign score_in.ready             = state_q == ST_IDLE;
	assign result_out.valid           = out_valid_q;
	assign result_out.avg_0           = avg_port[0];
	assign result_out.avg_1           = avg_port[1];
	assign result_out.avg_2           = avg_port[2];
	assign result_out.avg_3           = avg_port[3];
	assign result_out.raw_class       = out_raw_q;
	assign result_out.published_class = out_pub_q;
	assign result_out.fall_active     = out_active_q;

	// divider results only arrive while the sequencer waits for them
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIVWAIT)
		else $error("divider done outside wait step");

	// frame count never passes the window depth
	a_frames_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frames_q <= FW'(HISTORY_DEPTH))
		else $error("frame count beyond window");

	// outside a fall sequence the published class follows the raw class
	a_pub_raw: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_active_q) |-> out_pub_q == out_raw_q)
		else $error("published class differs from raw class outside a sequence");

	// a finished frame is published when the output register is free
	a_pub_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUB && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished frame not published");

endmodule
